// ===== hw/rtl/vniap_pkg.sv =====
package vniap_pkg;

  localparam int MAC_W = 48;
  localparam int LEN_W = 16;
  localparam int TS_W  = 64;
  localparam int CNT_W = 64;
  localparam int TPB_W = 32;

  // parameter defaults for the top level
  localparam int SOURCE_DEPTH_DEF = 16;
  localparam int ALIGN_BYTES_DEF  = 16;

  // source table handshake with the sequencer
  typedef struct packed {
    logic add;    // append the presented MAC
    logic start;  // begin a search for the presented MAC
  } tbl_ctrl_t;

  typedef struct packed {
    logic full;   // every entry holds a MAC
    logic done;   // search finished this cycle
    logic hit;    // search found the MAC, valid with done
  } tbl_stat_t;

endpackage

// ===== hw/rtl/vniap_src_table.sv =====
module vniap_src_table import vniap_pkg::*; #(
  parameter int SOURCE_DEPTH = SOURCE_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  tbl_ctrl_t        ctrl,
  input  logic [MAC_W-1:0] mac,
  output tbl_stat_t        stat
);

  localparam int AW = (SOURCE_DEPTH > 1) ? $clog2(SOURCE_DEPTH) : 1;
  localparam int CW = $clog2(SOURCE_DEPTH + 1);

  logic [MAC_W-1:0] mem [SOURCE_DEPTH];
  logic [MAC_W-1:0] rd_data_r;
  logic [CW-1:0]    count_r;
  logic [CW-1:0]    scan_idx_r;
  logic             cmp_v_r;
  logic             scanning_r;
  logic             issue;
  logic             match;
  logic             done;

  // one read issued per cycle, compared in the next cycle
  assign issue = scanning_r && (scan_idx_r < count_r);
  assign match = cmp_v_r && (rd_data_r == mac);
  assign done  = scanning_r && (match || (!issue && !cmp_v_r));

  assign stat.full = (count_r == CW'(SOURCE_DEPTH));
  assign stat.done = done;
  assign stat.hit  = match;

  always_ff @(posedge clk) begin
    if (ctrl.add && !stat.full) begin
      mem[count_r[AW-1:0]] <= mac;
    end
    if (issue) begin
      rd_data_r <= mem[scan_idx_r[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r    <= '0;
      scan_idx_r <= '0;
      cmp_v_r    <= 1'b0;
      scanning_r <= 1'b0;
    end else begin
      if (ctrl.add && !stat.full) begin
        count_r <= count_r + 1'b1;
      end
      if (ctrl.start) begin
        scanning_r <= 1'b1;
        scan_idx_r <= '0;
        cmp_v_r    <= 1'b0;
      end else if (done) begin
        scanning_r <= 1'b0;
        cmp_v_r    <= 1'b0;
      end else if (scanning_r) begin
        cmp_v_r <= issue;
        if (issue) begin
          scan_idx_r <= scan_idx_r + 1'b1;
        end
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(SOURCE_DEPTH))
    else $error("source table count beyond depth");

  a_full_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl.add && stat.full) |=> $stable(count_r))
    else $error("source table grew while full");

  a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.start |-> !scanning_r)
    else $error("search started while one is running");

endmodule

// ===== hw/rtl/vnic_ingress_admission_policer.sv =====
// Admission policer for one virtual interface. An item with opcode 1 appends src_mac to the
// source table; an item with opcode 0 is a packet, checked for address, source (when filtering
// is on), rate gate, buffer size, fifo room and memory, and answered with one result: verdict
// and, when admitted, buffer size and data offsets. Items are handled one at a time under a
// small sequencer around one shared 64-bit adder; in_tready is high only between items. A
// table add or an unaddressed packet goes from the address state to done; an admitted packet
// aligns the head padding by a reciprocal multiply and a multiply by the alignment, and moves
// the rate gate. With filtering on, the source is first searched for in the table entry by
// entry. A result waiting in the output register does not stop the next item being taken,
// but the next result waits in the done state until it has gone.
module vnic_ingress_admission_policer import vniap_pkg::*; #(
  parameter int SOURCE_DEPTH = SOURCE_DEPTH_DEF,
  parameter int ALIGN_BYTES  = ALIGN_BYTES_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // dest_mac[47:0], src_mac[95:48], length[111:96], now[175:112],
  // fifo_has_room[176], alloc_ok[177], zero[183:178]
  input  logic [183:0] in_tdata,
  // opcode[0]
  input  logic [0:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // accepted[0], verdict[3:1], buffer_bytes[19:4], data_start[35:20],
  // data_end[51:36], zero[55:52]
  output logic [55:0]  out_tdata,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_addr,
  input  logic [47:0]  cfg_wdata
);

  localparam int X_W    = LEN_W + 1;
  localparam int AL_LOG = $clog2(ALIGN_BYTES);
  localparam int RSH    = X_W + AL_LOG;
  localparam int RCW    = X_W + 1;
  localparam int PW     = X_W + RCW;
  localparam logic [LEN_W-1:0] ALIGN_M1 = LEN_W'(ALIGN_BYTES - 1);
  localparam logic [LEN_W-1:0] ALIGN_L  = LEN_W'(ALIGN_BYTES);
  localparam logic [RCW-1:0]   RECIP    =
    RCW'(((longint'(1) << RSH) + longint'(ALIGN_BYTES) - longint'(1)) / longint'(ALIGN_BYTES));

  localparam logic OP_ADD = 1'b1;

  typedef enum logic [2:0] {
    V_OK          = 3'd0,
    V_NOT_ADDR    = 3'd1,
    V_SRC_REFUSED = 3'd2,
    V_RATE_CLOSED = 3'd3,
    V_TOO_BIG     = 3'd4,
    V_FIFO_FULL   = 3'd5,
    V_NO_MEM      = 3'd6,
    V_TABLE_FULL  = 3'd7
  } verdict_t;

  typedef enum logic [2:0] {
    R_OWN_MAC  = 3'd0,
    R_TPB      = 3'd1,
    R_GRACE    = 3'd2,
    R_HEAD     = 3'd3,
    R_TAIL     = 3'd4,
    R_MIN_BUF  = 3'd5,
    R_MAX_BUF  = 3'd6,
    R_ALL_SRC  = 3'd7
  } reg_idx_t;

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_ADDR = 9'b000000010,
    S_SCAN = 9'b000000100,
    S_GATE = 9'b000001000,
    S_DIV  = 9'b000010000,
    S_GUPD = 9'b000100000,
    S_CNTB = 9'b001000000,
    S_CNTP = 9'b010000000,
    S_DONE = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;

  // configuration
  logic [MAC_W-1:0] own_mac_r;
  logic [TPB_W-1:0] tpb_r;
  logic [TPB_W-1:0] grace_r;
  logic [LEN_W-1:0] head_r, tail_r, min_buf_r, max_buf_r;
  logic             all_src_r;

  // item
  logic             op_r;
  logic [MAC_W-1:0] dmac_r, smac_r;
  logic [LEN_W-1:0] len_r;
  logic [TS_W-1:0]  now_r;
  logic             room_r, alloc_r;

  // working state
  logic [MAC_W-1:0] add_r;
  logic             gt_r;
  logic             admit_r;
  logic [LEN_W-1:0] buf_r;
  logic [X_W-1:0]   quo_r;
  logic [LEN_W-1:0] start_r;
  logic             res_acc_r;
  verdict_t         res_verdict_r;

  logic [TS_W-1:0]  gate_r;
  logic [CNT_W-1:0] rx_bytes_r, rx_pkts_r, drop_bytes_r, drop_pkts_r;

  // output register
  logic             out_valid_r;
  logic             out_acc_r;
  verdict_t         out_verdict_r;
  logic [LEN_W-1:0] out_buf_r, out_start_r, out_end_r;

  logic             in_fire, out_free;
  logic             addressed;
  tbl_ctrl_t        tbl_ctrl;
  tbl_stat_t        tbl_stat;

  logic [TS_W-1:0]  alu_a, alu_b;
  logic             alu_ci;
  logic [TS_W:0]    alu_sum;

  logic             gate_gt, gate_closed;
  logic [LEN_W-1:0] buf_raw, buf_fin;
  logic             too_big;
  logic [X_W-1:0]   div_x;
  logic [PW-1:0]    div_prod;

  assign in_tready  = (state_r == S_IDLE);
  assign in_fire    = in_tvalid && in_tready;
  assign out_free   = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0, out_end_r, out_start_r, out_buf_r, out_verdict_r, out_acc_r};

  assign addressed = (dmac_r == own_mac_r) || dmac_r[40];

  vniap_src_table #(
    .SOURCE_DEPTH(SOURCE_DEPTH)
  ) u_src_table (
    .clk  (clk),
    .rst_n(rst_n),
    .ctrl (tbl_ctrl),
    .mac  (smac_r),
    .stat (tbl_stat)
  );

  // shared 64-bit adder
  always_comb begin
    alu_a  = gate_r;
    alu_b  = '0;
    alu_ci = 1'b0;
    unique case (state_r)
      S_GATE: begin
        alu_a  = gate_r;
        alu_b  = ~now_r;
        alu_ci = 1'b1;
      end
      S_GUPD: begin
        alu_a = gt_r ? gate_r : now_r;
        alu_b = TS_W'(add_r);
      end
      S_CNTB: begin
        alu_a = admit_r ? rx_bytes_r : drop_bytes_r;
        alu_b = TS_W'(len_r);
      end
      S_CNTP: begin
        alu_a  = admit_r ? rx_pkts_r : drop_pkts_r;
        alu_ci = 1'b1;
      end
      default: begin
        alu_a = gate_r;
      end
    endcase
  end

  assign alu_sum = {1'b0, alu_a} + {1'b0, alu_b} + (TS_W+1)'(alu_ci);

  // carry out of gate - now means gate >= now, no wrap involved
  assign gate_gt     = alu_sum[TS_W] && (alu_sum[TS_W-1:0] != '0);
  assign gate_closed = gate_gt && (alu_sum[TS_W-1:0] > TS_W'(grace_r));

  assign buf_raw = head_r + len_r + tail_r + ALIGN_M1;
  assign too_big = buf_raw > max_buf_r;
  assign buf_fin = (buf_raw < min_buf_r) ? min_buf_r : buf_raw;

  // quotient by reciprocal multiply, exact for any 17-bit dividend
  assign div_x    = X_W'(head_r) + X_W'(ALIGN_M1);
  assign div_prod = PW'(div_x) * PW'(RECIP);

  always_comb begin
    state_nxt      = state_r;
    tbl_ctrl.add   = 1'b0;
    tbl_ctrl.start = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) state_nxt = S_ADDR;
      end
      S_ADDR: begin
        if (op_r == OP_ADD) begin
          tbl_ctrl.add = 1'b1;
          state_nxt    = S_DONE;
        end else if (!addressed) begin
          state_nxt = S_DONE;
        end else if (all_src_r) begin
          state_nxt = S_GATE;
        end else begin
          tbl_ctrl.start = 1'b1;
          state_nxt      = S_SCAN;
        end
      end
      S_SCAN: begin
        if (tbl_stat.done) state_nxt = tbl_stat.hit ? S_GATE : S_DONE;
      end
      S_GATE: begin
        if (gate_closed || too_big || !room_r || !alloc_r) begin
          state_nxt = S_CNTB;
        end else begin
          state_nxt = S_DIV;
        end
      end
      S_DIV:  state_nxt = S_GUPD;
      S_GUPD: state_nxt = S_CNTB;
      S_CNTB: state_nxt = S_CNTP;
      S_CNTP: state_nxt = S_DONE;
      S_DONE: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath, no reset needed
  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          op_r    <= in_tuser[0];
          dmac_r  <= in_tdata[47:0];
          smac_r  <= in_tdata[95:48];
          len_r   <= in_tdata[111:96];
          now_r   <= in_tdata[175:112];
          room_r  <= in_tdata[176];
          alloc_r <= in_tdata[177];
        end
      end
      S_ADDR: begin
        add_r   <= MAC_W'(tpb_r * len_r);
        admit_r <= 1'b0;
        if (op_r == OP_ADD) begin
          res_acc_r     <= !tbl_stat.full;
          res_verdict_r <= tbl_stat.full ? V_TABLE_FULL : V_OK;
        end else begin
          res_acc_r     <= 1'b0;
          res_verdict_r <= V_NOT_ADDR;
        end
      end
      S_SCAN: begin
        res_verdict_r <= V_SRC_REFUSED;
      end
      S_GATE: begin
        gt_r  <= gate_gt;
        buf_r <= buf_fin;
        quo_r <= X_W'(div_prod >> RSH);
        if (gate_closed) begin
          res_verdict_r <= V_RATE_CLOSED;
        end else if (too_big) begin
          res_verdict_r <= V_TOO_BIG;
        end else if (!room_r) begin
          res_verdict_r <= V_FIFO_FULL;
        end else if (!alloc_r) begin
          res_verdict_r <= V_NO_MEM;
        end else begin
          res_acc_r     <= 1'b1;
          res_verdict_r <= V_OK;
          admit_r       <= 1'b1;
        end
      end
      S_DIV: begin
        start_r <= LEN_W'(quo_r * ALIGN_L);
      end
      S_DONE: begin
        if (out_free) begin
          out_acc_r     <= res_acc_r;
          out_verdict_r <= res_verdict_r;
          out_buf_r     <= admit_r ? buf_r : '0;
          out_start_r   <= admit_r ? start_r : '0;
          out_end_r     <= admit_r ? LEN_W'(start_r + len_r) : '0;
        end
      end
      default: begin
        gt_r <= gt_r;
      end
    endcase
  end

  // control, configuration, gate and counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_valid_r  <= 1'b0;
      own_mac_r    <= '0;
      tpb_r        <= '0;
      grace_r      <= '0;
      head_r       <= LEN_W'(32);
      tail_r       <= LEN_W'(32);
      min_buf_r    <= LEN_W'(128);
      max_buf_r    <= LEN_W'(2048);
      all_src_r    <= 1'b1;
      gate_r       <= '0;
      rx_bytes_r   <= '0;
      rx_pkts_r    <= '0;
      drop_bytes_r <= '0;
      drop_pkts_r  <= '0;
    end else begin
      state_r <= state_nxt;

      if (state_r == S_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end

      if (cfg_we) begin
        unique case (reg_idx_t'(cfg_addr))
          R_OWN_MAC: own_mac_r <= cfg_wdata;
          R_TPB:     tpb_r     <= cfg_wdata[TPB_W-1:0];
          R_GRACE:   grace_r   <= cfg_wdata[TPB_W-1:0];
          R_HEAD:    head_r    <= cfg_wdata[LEN_W-1:0];
          R_TAIL:    tail_r    <= cfg_wdata[LEN_W-1:0];
          R_MIN_BUF: min_buf_r <= cfg_wdata[LEN_W-1:0];
          R_MAX_BUF: max_buf_r <= cfg_wdata[LEN_W-1:0];
          R_ALL_SRC: all_src_r <= cfg_wdata[0];
          default:   all_src_r <= all_src_r;
        endcase
      end

      if (state_r == S_GUPD) gate_r <= alu_sum[TS_W-1:0];

      if (state_r == S_CNTB) begin
        if (admit_r) rx_bytes_r   <= alu_sum[CNT_W-1:0];
        else         drop_bytes_r <= alu_sum[CNT_W-1:0];
      end
      if (state_r == S_CNTP) begin
        if (admit_r) rx_pkts_r   <= alu_sum[CNT_W-1:0];
        else         drop_pkts_r <= alu_sum[CNT_W-1:0];
      end
    end
  end

  a_gate_only_on_admit: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && !$stable(gate_r)) |-> ($past(state_r == S_GUPD) && $past(admit_r)))
    else $error("rate gate moved outside an admitted packet");

  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && out_valid_r && !$past(out_valid_r)) |-> $past(state_r == S_DONE))
    else $error("result raised outside the done state");

  a_verdict_matches: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_acc_r == (out_verdict_r == V_OK)))
    else $error("accepted flag disagrees with verdict");

  a_geometry_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_acc_r) |->
      (out_buf_r == '0 && out_start_r == '0 && out_end_r == '0))
    else $error("geometry reported for a refused item");

endmodule
